FILE: hw/rtl/fzr_pkg.sv
// Package for the zero-padded row FIR filter: sizes, register codes,
// the request record passed to the tap chain and the output rounding function.
// No dependencies.
`timescale 1ns / 1ps

package fzr_pkg;

    localparam int HALF_TAPS  = 5;
    localparam int TAP_COUNT  = 2 * HALF_TAPS + 1;
    localparam int COEF_WORDS = 3;
    localparam int SAMPLE_W   = 16;
    localparam int PROD_W     = 2 * SAMPLE_W;
    localparam int ACC_W      = PROD_W + 4;
    localparam int FRAC_BITS  = 15;
    localparam int SHIFT_W    = ACC_W + 1 - FRAC_BITS;
    localparam int WORD_W     = 64;
    localparam int ADDR_W     = 5;
    localparam int COUNT_W    = 3;

    localparam logic [1:0] REG_COEF_LOW  = 2'd0;
    localparam logic [1:0] REG_COEF_MID  = 2'd1;
    localparam logic [1:0] REG_COEF_HIGH = 2'd2;

    localparam logic [COUNT_W-1:0] HALF_CNT = COUNT_W'(HALF_TAPS);
    localparam logic [COUNT_W-1:0] FULL_CNT = COUNT_W'(HALF_TAPS + 1);

    typedef logic [COEF_WORDS-1:0][WORD_W-1:0] coef_words_t;

    typedef struct packed {
        logic                       valid;
        logic                       emit;
        logic                       last;
        logic signed [SAMPLE_W-1:0] sample;
    } issue_t;

    function automatic logic signed [SAMPLE_W-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W:0]     biased;
        logic signed [SHIFT_W-1:0] shifted;
        logic signed [SHIFT_W-1:0] hi_lim;
        logic signed [SHIFT_W-1:0] lo_lim;
        biased  = $signed({acc[ACC_W-1], acc}) + $signed((ACC_W + 1)'(1 << (FRAC_BITS - 1)));
        shifted = $signed(biased[ACC_W:FRAC_BITS]);
        hi_lim  = $signed(SHIFT_W'((1 << (SAMPLE_W - 1)) - 1));
        lo_lim  = -hi_lim - $signed(SHIFT_W'(1));
        if (shifted > hi_lim)
        begin
            return hi_lim[SAMPLE_W-1:0];
        end
        else if (shifted < lo_lim)
        begin
            return lo_lim[SAMPLE_W-1:0];
        end
        return shifted[SAMPLE_W-1:0];
    endfunction

endpackage

FILE: hw/rtl/fzr_if.sv
// Stream interfaces for the input samples and the filtered results.
// Depends on fzr_pkg for the sample width.
`timescale 1ns / 1ps

interface fzr_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [fzr_pkg::SAMPLE_W-1:0] sample;
    logic                                row_end;

    modport source (output valid, output sample, output row_end, input ready);
    modport sink (input valid, input sample, input row_end, output ready);
endinterface

interface fzr_out_if;
    logic                                valid;
    logic                                ready;
    logic signed [fzr_pkg::SAMPLE_W-1:0] filtered;
    logic                                row_done;

    modport source (output valid, output filtered, output row_done, input ready);
    modport sink (input valid, input filtered, input row_done, output ready);
endinterface

FILE: hw/rtl/fzr_cfg_regs.sv
// APB register file holding the three packed coefficient words.
// Depends on fzr_pkg.
`timescale 1ns / 1ps

module fzr_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fzr_pkg::ADDR_W-1:0]   paddr,
    input  logic [fzr_pkg::WORD_W-1:0]   pwdata,
    output logic [fzr_pkg::WORD_W-1:0]   prdata,
    output logic                         pready,
    output fzr_pkg::coef_words_t         coef_words
);

    fzr_pkg::coef_words_t coef_reg;
    fzr_pkg::coef_words_t coef_next;
    logic [1:0]           reg_sel;

    assign reg_sel    = paddr[fzr_pkg::ADDR_W-1:3];
    assign pready     = 1'b1;
    assign coef_words = coef_reg;

    always_comb
    begin
        coef_next = coef_reg;
        if (psel && penable && pwrite)
        begin
            unique case (reg_sel)
                fzr_pkg::REG_COEF_LOW:  coef_next[0] = pwdata;
                fzr_pkg::REG_COEF_MID:  coef_next[1] = pwdata;
                fzr_pkg::REG_COEF_HIGH: coef_next[2] = pwdata;
                default:                coef_next = coef_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            fzr_pkg::REG_COEF_LOW:  prdata = coef_reg[0];
            fzr_pkg::REG_COEF_MID:  prdata = coef_reg[1];
            fzr_pkg::REG_COEF_HIGH: prdata = coef_reg[2];
            default:                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

endmodule

FILE: hw/rtl/fzr_tap_cell.sv
// One cell of the transposed FIR chain: a product register and a partial sum
// register that adds the neighbor's partial sum. Depends on fzr_pkg.
`timescale 1ns / 1ps

module fzr_tap_cell (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic signed [fzr_pkg::SAMPLE_W-1:0] coef,
    input  logic signed [fzr_pkg::SAMPLE_W-1:0] sample,
    input  logic                               load_prod,
    input  logic                               load_sum,
    input  logic                               clear,
    input  logic signed [fzr_pkg::ACC_W-1:0]    sum_in,
    output logic signed [fzr_pkg::ACC_W-1:0]    sum_out
);

    logic signed [fzr_pkg::PROD_W-1:0] prod_reg;
    logic signed [fzr_pkg::PROD_W-1:0] prod_next;
    logic signed [fzr_pkg::ACC_W-1:0]  sum_reg;
    logic signed [fzr_pkg::ACC_W-1:0]  sum_next;

    assign sum_out = sum_reg;

    always_comb
    begin
        prod_next = load_prod ? fzr_pkg::PROD_W'(coef) * fzr_pkg::PROD_W'(sample) : prod_reg;
        sum_next  = sum_reg;
        if (load_sum)
        begin
            if (clear)
            begin
                sum_next = '0;
            end
            else
            begin
                sum_next = sum_in
                         + {{(fzr_pkg::ACC_W - fzr_pkg::PROD_W){prod_reg[fzr_pkg::PROD_W-1]}},
                            prod_reg};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
        end
    end

endmodule

FILE: hw/rtl/fzr_seq.sv
// Request sequencer: takes samples, inserts the zero flush steps after a row
// end and marks which steps produce a result. Depends on fzr_pkg and fzr_if.
`timescale 1ns / 1ps

module fzr_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    fzr_in_if.sink            in_ch,
    output fzr_pkg::issue_t   issue
);

    logic [fzr_pkg::COUNT_W-1:0] push_cnt_reg;
    logic [fzr_pkg::COUNT_W-1:0] push_cnt_next;
    logic [fzr_pkg::COUNT_W-1:0] flush_cnt_reg;
    logic [fzr_pkg::COUNT_W-1:0] flush_cnt_next;
    logic                        flushing;
    logic                        accept;

    assign flushing    = (flush_cnt_reg != '0);
    assign in_ch.ready = advance && !flushing;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        issue.valid  = accept || (flushing && advance);
        issue.sample = flushing ? '0 : in_ch.sample;
        issue.emit   = (push_cnt_reg >= fzr_pkg::HALF_CNT);
        issue.last   = flushing && (flush_cnt_reg == fzr_pkg::HALF_CNT);
    end

    always_comb
    begin
        push_cnt_next  = push_cnt_reg;
        flush_cnt_next = flush_cnt_reg;
        if (issue.valid)
        begin
            if (issue.last)
            begin
                push_cnt_next = '0;
            end
            else if (push_cnt_reg != fzr_pkg::FULL_CNT)
            begin
                push_cnt_next = push_cnt_reg + fzr_pkg::COUNT_W'(1);
            end
        end
        if (accept && in_ch.row_end)
        begin
            flush_cnt_next = fzr_pkg::COUNT_W'(1);
        end
        else if (flushing && advance)
        begin
            flush_cnt_next = issue.last ? '0 : flush_cnt_reg + fzr_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            push_cnt_reg  <= '0;
            flush_cnt_reg <= '0;
        end
        else
        begin
            push_cnt_reg  <= push_cnt_next;
            flush_cnt_reg <= flush_cnt_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_take_in_flush: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> (flush_cnt_reg == '0))
        else $error("input taken during flush");
    a_row_end_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_ch.row_end) |=> !in_ch.ready)
        else $error("row end did not start flush");
    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        issue.last |-> issue.emit)
        else $error("final flush step produces no result");
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (issue.valid && issue.last) |=> (push_cnt_reg == '0))
        else $error("row count not cleared after flush");
`endif

endmodule

FILE: hw/rtl/fir_filter_zero_padded_rows.sv
// Top level of the zero-padded row FIR filter: register file, sequencer,
// tap cell chain and output register. Depends on fzr_pkg, fzr_if and submodules.
//
// Usage: samples arrive on in_ch (valid/ready), one row after another, with
// row_end set on the last sample of each row. Results leave on out_ch; the
// last result of each row carries row_done. Coefficients are written over
// the APB port at byte addresses 0, 8 and 16 while the block is idle.
// Within a row one sample is taken per cycle while the output does not stall.
// After a row end the block runs five zero flush steps, one per cycle while
// the output does not stall, and takes no sample meanwhile. Each step passes
// through a product stage, a partial sum stage and the output register before
// its result appears.
// A request stalled at the output holds the whole chain; a waiting result
// does not block steps that produce no result.
// Reset clears the coefficients, the partial sums and the row counters.
`timescale 1ns / 1ps

module fir_filter_zero_padded_rows (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [fzr_pkg::ADDR_W-1:0] paddr,
    input  logic [fzr_pkg::WORD_W-1:0] pwdata,
    output logic [fzr_pkg::WORD_W-1:0] prdata,
    output logic                       pready,
    fzr_in_if.sink                     in_ch,
    fzr_out_if.source                  out_ch
);

    fzr_pkg::coef_words_t coef_words;
    fzr_pkg::issue_t      issue;
    logic                 advance;

    logic v1_reg, v1_next, emit1_reg, emit1_next, last1_reg, last1_next;
    logic v2_reg, v2_next, emit2_reg, emit2_next, last2_reg, last2_next;
    logic out_valid_reg, out_valid_next;
    logic signed [fzr_pkg::SAMPLE_W-1:0] filtered_reg, filtered_next;
    logic row_done_reg, row_done_next;

    logic signed [fzr_pkg::ACC_W-1:0] chain_sum [fzr_pkg::TAP_COUNT+1];

    fzr_cfg_regs u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .coef_words (coef_words)
    );

    fzr_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .in_ch   (in_ch),
        .issue   (issue)
    );

    assign advance = out_ch.ready || !out_valid_reg || !(v2_reg && emit2_reg);

    assign chain_sum[fzr_pkg::TAP_COUNT] = '0;

    for (genvar i = 0; i < fzr_pkg::TAP_COUNT; i++)
    begin : g_cell
        localparam int TAP  = fzr_pkg::TAP_COUNT - 1 - i;
        localparam int WORD = TAP / 4;
        localparam int LANE = TAP % 4;

        fzr_tap_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .coef      ($signed(coef_words[WORD][fzr_pkg::SAMPLE_W*LANE +: fzr_pkg::SAMPLE_W])),
            .sample    (issue.sample),
            .load_prod (advance && issue.valid),
            .load_sum  (advance && v1_reg),
            .clear     ((i != 0) && last1_reg),
            .sum_in    (chain_sum[i+1]),
            .sum_out   (chain_sum[i])
        );
    end

    always_comb
    begin
        v1_next    = v1_reg;
        emit1_next = emit1_reg;
        last1_next = last1_reg;
        v2_next    = v2_reg;
        emit2_next = emit2_reg;
        last2_next = last2_reg;
        if (advance)
        begin
            v1_next    = issue.valid;
            emit1_next = issue.emit;
            last1_next = issue.last;
            v2_next    = v1_reg;
            emit2_next = emit1_reg;
            last2_next = last1_reg;
        end
        out_valid_next = out_valid_reg;
        filtered_next  = filtered_reg;
        row_done_next  = row_done_reg;
        if (!out_valid_reg || out_ch.ready)
        begin
            out_valid_next = v2_reg && emit2_reg;
            filtered_next  = fzr_pkg::round_sat(chain_sum[0]);
            row_done_next  = last2_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            emit1_reg     <= 1'b0;
            last1_reg     <= 1'b0;
            v2_reg        <= 1'b0;
            emit2_reg     <= 1'b0;
            last2_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            v1_reg        <= v1_next;
            emit1_reg     <= emit1_next;
            last1_reg     <= last1_next;
            v2_reg        <= v2_next;
            emit2_reg     <= emit2_next;
            last2_reg     <= last2_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        filtered_reg <= filtered_next;
        row_done_reg <= row_done_next;
    end

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.filtered = filtered_reg;
    assign out_ch.row_done = row_done_reg;

endmodule
